### src/afbd_pkg.sv
// Shared types, constants and the 2^x mantissa table of the box decoder.
// Used by every module of anchor_free_box_decode_core; depends on nothing.
package afbd_pkg;

    localparam int MAX_SIDE    = 1024;
    localparam int MAX_CLASSES = 128;
    localparam int MAX_IMAGES  = 16;
    localparam int IMG_LIMIT   = (MAX_IMAGES > 16) ? 16 : MAX_IMAGES;

    localparam int SIDE_W  = 11;
    localparam int CLASS_W = 8;
    localparam int THR_W   = 17;
    localparam int IMGS_W  = 5;
    localparam int RAW_W   = 16;
    localparam int OUT_W   = 96;

    // register indexes of the configuration channel
    localparam logic [1:0] REG_INPUT_SIDE  = 2'd0;
    localparam logic [1:0] REG_CLASS_COUNT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD   = 2'd2;
    localparam logic [1:0] REG_IMAGE_COUNT = 2'd3;

    localparam logic [SIDE_W-1:0]  RST_INPUT_SIDE  = 11'd640;
    localparam logic [CLASS_W-1:0] RST_CLASS_COUNT = 8'd80;
    localparam logic [THR_W-1:0]   RST_THRESHOLD   = 17'd16384;
    localparam logic [IMGS_W-1:0]  RST_IMAGE_COUNT = 5'd1;

    // word kinds, set by the position inside an anchor record
    localparam logic [2:0] KIND_CX    = 3'd0;
    localparam logic [2:0] KIND_CY    = 3'd1;
    localparam logic [2:0] KIND_W     = 3'd2;
    localparam logic [2:0] KIND_H     = 3'd3;
    localparam logic [2:0] KIND_OBJ   = 3'd4;
    localparam logic [2:0] KIND_SCORE = 3'd5;

    localparam logic [1:0] STAGE_LAST = 2'd2;

    // log2(e) in Q16
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SIDE_W-1:0]  input_side;
        logic [CLASS_W-1:0] class_count;
        logic [THR_W-1:0]   score_threshold;
        logic [IMGS_W-1:0]  image_count;
    } afbd_cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [RAW_W-1:0]   value;
        logic [1:0]         stage;
        logic [6:0]         grid;
        logic [3:0]         image;
        logic [6:0]         class_pos;
    } afbd_item_t;

    // 2^(i/16) in Q16
    function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
        logic [17:0] r;
        case (idx)
            5'd0:    r = 18'd65536;
            5'd1:    r = 18'd68438;
            5'd2:    r = 18'd71468;
            5'd3:    r = 18'd74632;
            5'd4:    r = 18'd77936;
            5'd5:    r = 18'd81386;
            5'd6:    r = 18'd84990;
            5'd7:    r = 18'd88752;
            5'd8:    r = 18'd92682;
            5'd9:    r = 18'd96785;
            5'd10:   r = 18'd101070;
            5'd11:   r = 18'd105545;
            5'd12:   r = 18'd110218;
            5'd13:   r = 18'd115063;
            5'd14:   r = 18'd120142;
            5'd15:   r = 18'd125401;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

### src/afbd_regs.sv
// Configuration register file of the box decoder.
// Depends on afbd_pkg for the register indexes and reset values.
module afbd_regs
    import afbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [THR_W-1:0]  cfg_data,
    output afbd_cfg_t         cfg
);

    afbd_cfg_t cfg_reg;
    afbd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INPUT_SIDE:  cfg_next.input_side      = cfg_data[SIDE_W-1:0];
                REG_CLASS_COUNT: cfg_next.class_count     = cfg_data[CLASS_W-1:0];
                REG_THRESHOLD:   cfg_next.score_threshold = cfg_data;
                REG_IMAGE_COUNT: cfg_next.image_count     = cfg_data[IMGS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_side      <= RST_INPUT_SIDE;
            cfg_reg.class_count     <= RST_CLASS_COUNT;
            cfg_reg.score_threshold <= RST_THRESHOLD;
            cfg_reg.image_count     <= RST_IMAGE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/afbd_front.sv
// Front end: accepts tensor words, tracks record position, grid and image,
// and tags each word with its kind. Depends on afbd_pkg.
module afbd_front
    import afbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  afbd_cfg_t        cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [RAW_W-1:0] s_tdata,     // [15:0] raw_value
    input  logic             queue_full,
    output logic             push,
    output afbd_item_t       push_item
);

    logic [7:0] field_position_reg, field_position_next;
    logic [6:0] grid_column_reg, grid_column_next;
    logic [6:0] grid_row_reg, grid_row_next;
    logic [1:0] stride_stage_reg, stride_stage_next;
    logic [3:0] current_image_reg, current_image_next;

    logic [CLASS_W-1:0] eff_classes;
    logic [8:0]         last_pos;
    logic [SIDE_W-1:0]  side_clamped;
    logic [SIDE_W-1:0]  side_aligned;
    logic [SIDE_W-1:0]  side_shifted;
    logic [7:0]         grid_cells;
    logic [IMGS_W-1:0]  eff_images;
    logic [7:0]         col_inc;
    logic [7:0]         row_inc;
    logic [4:0]         img_inc;
    logic [2:0]         kind_c;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        if (cfg.class_count == '0)
            eff_classes = CLASS_W'(1);
        else if (cfg.class_count > CLASS_W'(MAX_CLASSES))
            eff_classes = CLASS_W'(MAX_CLASSES);
        else
            eff_classes = cfg.class_count;
        last_pos = 9'd4 + {1'b0, eff_classes};

        if (cfg.input_side < SIDE_W'(32))
            side_clamped = SIDE_W'(32);
        else if (cfg.input_side > SIDE_W'(MAX_SIDE))
            side_clamped = SIDE_W'(MAX_SIDE);
        else
            side_clamped = cfg.input_side;
        side_aligned = {side_clamped[SIDE_W-1:5], 5'b0};
        side_shifted = side_aligned >> (3'd3 + {1'b0, stride_stage_reg});
        if (side_shifted > SIDE_W'(128))
            grid_cells = 8'd128;
        else if (side_shifted == '0)
            grid_cells = 8'd1;
        else
            grid_cells = side_shifted[7:0];

        if (cfg.image_count == '0)
            eff_images = IMGS_W'(1);
        else if (cfg.image_count > IMGS_W'(IMG_LIMIT))
            eff_images = IMGS_W'(IMG_LIMIT);
        else
            eff_images = cfg.image_count;
    end

    always_comb
    begin
        unique case (field_position_reg)
            8'd0:    kind_c = KIND_CX;
            8'd1:    kind_c = KIND_CY;
            8'd2:    kind_c = KIND_W;
            8'd3:    kind_c = KIND_H;
            8'd4:    kind_c = KIND_OBJ;
            default: kind_c = KIND_SCORE;
        endcase
        push_item.kind      = kind_c;
        push_item.value     = s_tdata;
        push_item.stage     = stride_stage_reg;
        push_item.grid      = (field_position_reg == 8'd0) ? grid_column_reg : grid_row_reg;
        push_item.image     = current_image_reg;
        push_item.class_pos = 7'(field_position_reg - 8'd5);
    end

    // walk record position, then column, row, stride and image
    always_comb
    begin
        field_position_next = field_position_reg;
        grid_column_next    = grid_column_reg;
        grid_row_next       = grid_row_reg;
        stride_stage_next   = stride_stage_reg;
        current_image_next  = current_image_reg;
        col_inc = {1'b0, grid_column_reg} + 8'd1;
        row_inc = {1'b0, grid_row_reg} + 8'd1;
        img_inc = {1'b0, current_image_reg} + 5'd1;
        if (push)
        begin
            if ({1'b0, field_position_reg} >= last_pos)
            begin
                field_position_next = '0;
                if (col_inc < grid_cells)
                    grid_column_next = col_inc[6:0];
                else
                begin
                    grid_column_next = '0;
                    if (row_inc < grid_cells)
                        grid_row_next = row_inc[6:0];
                    else
                    begin
                        grid_row_next = '0;
                        if (stride_stage_reg < STAGE_LAST)
                            stride_stage_next = stride_stage_reg + 2'd1;
                        else
                        begin
                            stride_stage_next = '0;
                            if (img_inc >= eff_images)
                                current_image_next = '0;
                            else
                                current_image_next = img_inc[3:0];
                        end
                    end
                end
            end
            else
            begin
                field_position_next = field_position_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_position_reg <= '0;
            grid_column_reg    <= '0;
            grid_row_reg       <= '0;
            stride_stage_reg   <= '0;
            current_image_reg  <= '0;
        end
        else
        begin
            field_position_reg <= field_position_next;
            grid_column_reg    <= grid_column_next;
            grid_row_reg       <= grid_row_next;
            stride_stage_reg   <= stride_stage_next;
            current_image_reg  <= current_image_next;
        end
    end

`ifndef SYNTHESIS
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        stride_stage_reg <= STAGE_LAST)
        else $error("stride stage beyond stride 32");
`endif

endmodule

### src/afbd_queue.sv
// Short word queue between front and back end of the box decoder.
// Depends on afbd_pkg for the item type and depth.
module afbd_queue
    import afbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  afbd_item_t push_item,
    output logic       full,
    input  logic       pop,
    output afbd_item_t head_item,
    output logic       empty
);

    afbd_item_t q_mem [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

### src/afbd_back.sv
// Back end: centers, table exp sizes, scores, edges and the result register.
// Depends on afbd_pkg for item type, kinds and the 2^x table.
module afbd_back
    import afbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [THR_W-1:0] score_threshold,
    input  afbd_item_t       head_item,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [3:0] image_index, [10:4] class_index, [26:11] box_left, [42:27] box_top,
    // [58:43] box_width, [74:59] box_height, [91:75] confidence, [95:92] zero
    output logic [OUT_W-1:0] m_tdata
);

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         stage;
        logic [3:0]         image;
        logic [6:0]         class_pos;
        logic signed [33:0] prod;
        logic signed [23:0] center;
    } s1_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         image;
        logic [6:0]         class_pos;
        logic               pass;
        logic [16:0]        conf;
        logic [16:0]        base;
        logic [12:0]        delta;
        logic               sat_hi;
        logic               to_zero;
        logic [4:0]         shamt;
        logic signed [23:0] center;
    } s2_t;

    typedef struct packed {
        logic        pass;
        logic [3:0]  image;
        logic [6:0]  class_pos;
        logic [16:0] conf;
    } s3_t;

    function automatic logic [15:0] edge_round(input logic signed [24:0] x);
        logic signed [25:0] adj;
        logic signed [17:0] q;
        logic [15:0]        r;
        // half away from zero: +128 above zero, +127 below, then floor
        adj = {x[24], x} + 26'sd127 + {25'b0, !x[24]};
        q   = adj[25:8];
        if (q > 18'sd32767)
            r = 16'h7FFF;
        else if (q < -18'sd32768)
            r = 16'h8000;
        else
            r = q[15:0];
        return r;
    endfunction

    logic advance;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;

    logic signed [15:0] obj_held_reg;
    logic signed [23:0] center_x_held_reg, center_y_held_reg;
    logic [15:0]        width_held_reg, height_held_reg;
    logic signed [24:0] xl_reg, yt_reg;
    logic [15:0]        left_reg, top_reg;

    logic               m_tvalid_reg;
    logic [3:0]         out_image_reg;
    logic [6:0]         out_class_reg;
    logic [15:0]        out_left_reg, out_top_reg, out_width_reg, out_height_reg;
    logic [16:0]        out_conf_reg;

    logic signed [17:0] mul_a;
    logic signed [33:0] prod_c;
    logic signed [17:0] grid_sum;
    logic [2:0]         stride_shift;

    logic signed [9:0]  k_c;
    logic [3:0]         idx_c;
    logic [19:0]        frac_c;
    logic [17:0]        base_c, next_c;
    logic [12:0]        diff_c;
    logic [32:0]        delta_c;
    logic signed [10:0] e_c;
    logic [10:0]        neg_e;

    logic [17:0]        mant_c;
    logic [23:0]        rnd_c;
    logic [23:0]        q_c;
    logic [15:0]        size_c;

    assign advance = !m_tvalid_reg || m_tready;
    assign pop     = advance && !empty;

    // pop: one shared multiplier for exp argument and confidence product
    always_comb
    begin
        if (head_item.kind == KIND_SCORE)
            mul_a = {{2{obj_held_reg[15]}}, obj_held_reg};
        else
            mul_a = LOG2E_Q16;
        prod_c       = mul_a * $signed(head_item.value);
        grid_sum     = {{2{head_item.value[15]}}, head_item.value}
                       + $signed({3'b0, head_item.grid, 8'b0});
        stride_shift = 3'd3 + {1'b0, head_item.stage};
        s1_next.kind      = head_item.kind;
        s1_next.stage     = head_item.stage;
        s1_next.image     = head_item.image;
        s1_next.class_pos = head_item.class_pos;
        s1_next.prod      = prod_c;
        s1_next.center    = {{6{grid_sum[17]}}, grid_sum} <<< stride_shift;
    end

    // stage 1: table interpolation and exponent; threshold compare
    always_comb
    begin
        k_c     = s1_reg.prod[33:24];
        idx_c   = s1_reg.prod[23:20];
        frac_c  = s1_reg.prod[19:0];
        base_c  = pow2_frac({1'b0, idx_c});
        next_c  = pow2_frac({1'b0, idx_c} + 5'd1);
        diff_c  = 13'(next_c - base_c);
        delta_c = {20'b0, diff_c} * {13'b0, frac_c};
        e_c     = {k_c[9], k_c} + $signed({9'b0, s1_reg.stage}) - 11'sd13;
        neg_e   = 11'(-e_c);

        s2_next.kind      = s1_reg.kind;
        s2_next.image     = s1_reg.image;
        s2_next.class_pos = s1_reg.class_pos;
        s2_next.pass      = (s1_reg.kind == KIND_SCORE)
                            && (s1_reg.prod > $signed({17'b0, score_threshold}));
        if (s1_reg.prod > 34'sd65536)
            s2_next.conf = 17'h10000;
        else if (s1_reg.prod[33])
            s2_next.conf = '0;
        else
            s2_next.conf = s1_reg.prod[16:0];
        s2_next.base    = base_c[16:0];
        s2_next.delta   = delta_c[32:20];
        s2_next.sat_hi  = !e_c[10];
        s2_next.to_zero = (e_c <= -11'sd24);
        s2_next.shamt   = neg_e[4:0];
        s2_next.center  = s1_reg.center;
    end

    // stage 2: scale, round half up and saturate the size
    always_comb
    begin
        mant_c = {1'b0, s2_reg.base} + {5'b0, s2_reg.delta};
        rnd_c  = {6'b0, mant_c} + (24'd1 << (s2_reg.shamt - 5'd1));
        q_c    = rnd_c >> s2_reg.shamt;
        if (s2_reg.sat_hi)
            size_c = 16'hFFFF;
        else if (s2_reg.to_zero)
            size_c = '0;
        else if (q_c > 24'd65535)
            size_c = 16'hFFFF;
        else
            size_c = q_c[15:0];

        s3_next.pass      = s2_reg.pass;
        s3_next.image     = s2_reg.image;
        s3_next.class_pos = s2_reg.class_pos;
        s3_next.conf      = s2_reg.conf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_tvalid_reg <= s3_valid_reg && s3_reg.pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            if (s3_valid_reg && s3_reg.pass)
            begin
                out_image_reg  <= s3_reg.image;
                out_class_reg  <= s3_reg.class_pos;
                out_left_reg   <= left_reg;
                out_top_reg    <= top_reg;
                out_width_reg  <= width_held_reg;
                out_height_reg <= height_held_reg;
                out_conf_reg   <= s3_reg.conf;
            end
        end
        // edges follow the held geometry every cycle
        xl_reg   <= {center_x_held_reg[23], center_x_held_reg}
                    - $signed({2'b0, width_held_reg, 7'b0});
        yt_reg   <= {center_y_held_reg[23], center_y_held_reg}
                    - $signed({2'b0, height_held_reg, 7'b0});
        left_reg <= edge_round(xl_reg);
        top_reg  <= edge_round(yt_reg);
    end

    // record geometry: objectness at pop, centers and sizes leaving stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_held_reg      <= '0;
            center_x_held_reg <= '0;
            center_y_held_reg <= '0;
            width_held_reg    <= '0;
            height_held_reg   <= '0;
        end
        else if (advance)
        begin
            if (pop && head_item.kind == KIND_OBJ)
                obj_held_reg <= $signed(head_item.value);
            if (s2_valid_reg)
            begin
                case (s2_reg.kind)
                    KIND_CX: center_x_held_reg <= s2_reg.center;
                    KIND_CY: center_y_held_reg <= s2_reg.center;
                    KIND_W:  width_held_reg    <= size_c;
                    KIND_H:  height_held_reg   <= size_c;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_conf_reg, out_height_reg, out_width_reg,
                       out_top_reg, out_left_reg, out_class_reg, out_image_reg};

`ifndef SYNTHESIS
    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_conf_reg != '0 && out_conf_reg <= 17'h10000))
        else $error("confidence out of range on a passing box");

    a_size_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg && s2_reg.kind == KIND_W && s2_reg.sat_hi)
        |=> width_held_reg == 16'hFFFF)
        else $error("saturated width not held");
`endif

endmodule

### src/anchor_free_box_decode_core.sv
// Anchor-free box decoder: one Q8.8 tensor word in per cycle, candidate boxes out.
// From input accept to result valid a word passes the queue, three back stages and the output register.
// Throughput: one word per cycle; a held result stalls the back end, and s_tready
// drops once the four-word queue has filled behind it.
// Reset: async active low clears counters, queue, pipeline valids and held geometry;
// configuration returns to side 640, 80 classes, threshold 16384, one image.
module anchor_free_box_decode_core
    import afbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [RAW_W-1:0] s_tdata,     // [15:0] raw_value
    output logic             m_tvalid,
    input  logic             m_tready,
    // [3:0] image_index, [10:4] class_index, [26:11] box_left, [42:27] box_top,
    // [58:43] box_width, [74:59] box_height, [91:75] confidence, [95:92] zero
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [THR_W-1:0] cfg_data
);

    afbd_cfg_t  cfg;
    afbd_item_t push_item;
    afbd_item_t head_item;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;

    afbd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    afbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    afbd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .score_threshold (cfg.score_threshold),
        .head_item       (head_item),
        .empty           (queue_empty),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule
